>>> design/mrrp_pkg.sv
`default_nettype none
package mrrp_pkg;

    typedef enum logic [2:0] {
        OP_COMMIT  = 3'd0,
        OP_CONSUME = 3'd1,
        OP_ATTACH  = 3'd2,
        OP_DETACH  = 3'd3,
        OP_ADD_TAG = 3'd4,
        OP_SPACE   = 3'd5,
        OP_TAGS    = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DETACHED = 2'd1,
        ST_TAG_FULL = 2'd2
    } status_t;

    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 12;
    localparam int OFF_W       = 64;
    localparam int PAY_W       = 32;
    localparam int CFG_W       = 13;

endpackage
`default_nettype wire

>>> design/mrrp_mod.sv
`default_nettype none
module mrrp_mod #(
    parameter int MW = 13,
    parameter int SW = 13,
    parameter int PW = 12
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [MW-1:0] dividend,
    input  wire logic [SW-1:0] divisor,
    output logic               done,
    output logic [PW-1:0]      rem
);
    import mrrp_pkg::*;

    localparam int BW = $clog2(MW + 1);

    logic [MW-1:0] dvd_reg;
    logic [SW-1:0] dsr_reg;
    logic [SW-1:0] rem_reg;
    logic [BW-1:0] bits_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [SW:0]   trial;

    // one quotient bit per cycle, restoring form
    assign trial = {rem_reg, dvd_reg[MW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                bits_reg <= BW'(MW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[MW-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg}) begin
                    rem_reg <= SW'(trial - {1'b0, dsr_reg});
                end else begin
                    rem_reg <= SW'(trial);
                end
                bits_reg <= bits_reg - 1'b1;
                if (bits_reg == BW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = PW'(rem_reg);

endmodule
`default_nettype wire

>>> design/multi_reader_ring_pointer_tags.sv
`default_nettype none
// commit and attach run the remainder unit twice, consume three times; other operations answer directly
// space query: one remainder run for the write pointer and one per attached reader while scanning
// the reader slots, plus a pass over the stored tags when pruning; tag query: a pass over the stored
// tags to mark matches, then one result sent per match; throughput: one transaction at a time,
// set by the shared bit-serial remainder unit (W = 13 quotient bits per run)
// reset: synchronous active-low aresetn clears write pointer and total, attach bits, tag count
module multi_reader_ring_pointer_tags #(
    parameter int DEPTH     = 4096,
    parameter int READERS   = 8,
    parameter int TAG_SLOTS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: ring size in slots
    input  wire logic         cfg_wr_en,
    input  wire logic [mrrp_pkg::CFG_W-1:0] cfg_wr_data,
    // input transactions
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // reader, count, new_tag_offset, new_tag_payload, range_start, range_end
    input  wire logic [239:0] s_tdata,
    // operation
    input  wire logic [2:0]   s_tuser,
    // result transactions
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, space_free, backlog, tag_found, found_offset, found_payload
    output logic [127:0]      m_tdata,
    // last
    output logic              m_tlast
);
    import mrrp_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int SW  = $clog2(DEPTH + 1);
    localparam int MW  = ((PW > CNT_W) ? PW : CNT_W) + 1;
    localparam int CW  = (SW > CFG_W) ? SW : CFG_W;
    localparam int RW  = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int TW  = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
    localparam int TCW = $clog2(TAG_SLOTS + 1);
    localparam int NW  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_MOD_WAIT,
        S_C1, S_C2,
        S_N1, S_N2, S_N3,
        S_A1, S_A2, S_A3,
        S_S0, S_S1, S_S2, S_SDONE, S_SOUT,
        S_P_RD, S_P_CHK,
        S_Q_RD, S_Q_CHK, S_E_SCAN, S_E_CHK,
        S_EMIT
    } state_t;

    state_t state_reg, ret_reg;

    // latched transaction
    op_t             op_reg;
    logic [2:0]      rdr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OFF_W-1:0] noff_reg, rs_reg, re_reg;
    logic [PAY_W-1:0] npay_reg;

    // pointer state
    logic [SW-1:0]    bs_reg;
    logic [PW-1:0]    wp_reg;
    logic [OFF_W-1:0] wtot_reg;
    logic [PW-1:0]    rp_reg   [READERS];
    logic [OFF_W-1:0] rtot_reg [READERS];
    logic [READERS-1:0] att_reg;
    logic [OFF_W-1:0] prior_reg;
    logic [TCW-1:0]   tcount_reg;

    // sequencer scratch
    logic [PW-1:0]    tmp_reg;
    logic [RW:0]      idx_reg;
    logic             any_reg;
    logic [PW-1:0]    most_reg;
    logic [OFF_W-1:0] minr_reg;
    logic [TCW-1:0]   ti_reg, keep_reg;
    logic [TAG_SLOTS-1:0] mask_reg;
    logic [NW-1:0]    nres_reg;

    // result register
    logic             m_tvalid_reg, m_tlast_reg, m_found_reg;
    status_t          m_status_reg;
    logic [CNT_W-1:0] m_space_reg, m_backlog_reg;
    logic [OFF_W-1:0] m_off_reg;
    logic [PAY_W-1:0] m_pay_reg;

    // shared remainder unit
    logic             mod_done;
    logic [MW-1:0]    mod_in_reg;
    logic             mod_start_reg;
    logic [PW-1:0]    mod_rem;

    // tag table
    logic [OFF_W-1:0] tag_off_mem [TAG_SLOTS];
    logic [PAY_W-1:0] tag_pay_mem [TAG_SLOTS];
    logic [OFF_W-1:0] tag_rd_off;
    logic [PAY_W-1:0] tag_rd_pay;
    logic             tag_we;
    logic [TW-1:0]    tag_wa;
    logic [OFF_W-1:0] tag_wd_off;
    logic [PAY_W-1:0] tag_wd_pay;

    logic             r_ok, r_valid;
    logic [RW-1:0]    ri;
    logic [CW-1:0]    cfg_ext;
    logic [SW-1:0]    bs_next;
    logic [TAG_SLOTS-1:0] mask_rest;
    logic [PW-1:0]    idx_back;
    logic [OFF_W-1:0] idx_tot;

    // reduce a value below twice the size by one compare and subtract
    function automatic logic [PW-1:0] csub(input logic [SW:0] x, input logic [SW-1:0] bs);
        logic [SW:0] y;
        y = (x >= {1'b0, bs}) ? x - {1'b0, bs} : x;
        return PW'(y);
    endfunction

    mrrp_mod #(.MW(MW), .SW(SW), .PW(PW)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start_reg),
        .dividend (mod_in_reg),
        .divisor  (bs_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // slot checks: a reader number past the slot count is never attached
    assign r_ok    = (32'(rdr_reg) < READERS);
    assign ri      = RW'(rdr_reg);
    assign r_valid = r_ok && att_reg[ri];

    // clamp written size into 2..DEPTH
    assign cfg_ext = CW'(cfg_wr_data);
    always_comb begin
        if (cfg_ext < CW'(2)) begin
            bs_next = SW'(2);
        end else if (cfg_ext > CW'(DEPTH)) begin
            bs_next = SW'(DEPTH);
        end else begin
            bs_next = SW'(cfg_ext);
        end
    end

    // backlog of the slot under the scan pointer
    assign idx_back = csub({1'b0, SW'(tmp_reg)} + {1'b0, bs_reg} - {1'b0, SW'(mod_rem)}, bs_reg);
    assign idx_tot  = rtot_reg[idx_reg[RW-1:0]];

    always_comb begin
        mask_rest = mask_reg;
        mask_rest[ti_reg[TW-1:0]] = 1'b0;
    end

    // tag table writes: append on add, compaction on prune
    always_comb begin
        tag_we     = 1'b0;
        tag_wa     = tcount_reg[TW-1:0];
        tag_wd_off = noff_reg;
        tag_wd_pay = npay_reg;
        case (state_reg)
            S_DISPATCH: begin
                tag_we = (op_reg == OP_ADD_TAG) && (tcount_reg < TCW'(TAG_SLOTS));
            end
            S_P_CHK: begin
                tag_we     = (tag_rd_off >= prior_reg);
                tag_wa     = keep_reg[TW-1:0];
                tag_wd_off = tag_rd_off;
                tag_wd_pay = tag_rd_pay;
            end
            default: begin
                tag_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_off_mem[tag_wa] <= tag_wd_off;
            tag_pay_mem[tag_wa] <= tag_wd_pay;
        end
        tag_rd_off <= tag_off_mem[ti_reg[TW-1:0]];
        tag_rd_pay <= tag_pay_mem[ti_reg[TW-1:0]];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            bs_reg        <= SW'((DEPTH < 4096) ? DEPTH : 4096);
            wp_reg        <= '0;
            wtot_reg      <= '0;
            att_reg       <= '0;
            prior_reg     <= '0;
            tcount_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            mod_start_reg <= 1'b0;
        end else begin
            mod_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                bs_reg <= bs_next;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg   <= op_t'(s_tuser);
                        rdr_reg  <= s_tdata[2:0];
                        cnt_reg  <= s_tdata[14:3];
                        noff_reg <= s_tdata[78:15];
                        npay_reg <= s_tdata[110:79];
                        rs_reg   <= s_tdata[174:111];
                        re_reg   <= s_tdata[238:175];
                        // default result: all zero, single and last
                        m_status_reg  <= ST_OK;
                        m_space_reg   <= '0;
                        m_backlog_reg <= '0;
                        m_found_reg   <= 1'b0;
                        m_off_reg     <= '0;
                        m_pay_reg     <= '0;
                        m_tlast_reg   <= 1'b1;
                        state_reg     <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (op_reg)
                        OP_COMMIT: begin
                            mod_in_reg    <= MW'(wp_reg);
                            mod_start_reg <= 1'b1;
                            ret_reg       <= S_C1;
                            state_reg     <= S_MOD_WAIT;
                        end
                        OP_CONSUME: begin
                            if (!r_valid) begin
                                m_status_reg <= ST_DETACHED;
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= S_EMIT;
                            end else begin
                                mod_in_reg    <= MW'(rp_reg[ri]);
                                mod_start_reg <= 1'b1;
                                ret_reg       <= S_N1;
                                state_reg     <= S_MOD_WAIT;
                            end
                        end
                        OP_ATTACH: begin
                            if (!r_ok) begin
                                m_status_reg <= ST_DETACHED;
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= S_EMIT;
                            end else begin
                                mod_in_reg    <= MW'(cnt_reg);
                                mod_start_reg <= 1'b1;
                                ret_reg       <= S_A1;
                                state_reg     <= S_MOD_WAIT;
                            end
                        end
                        OP_DETACH: begin
                            if (!r_valid) begin
                                m_status_reg <= ST_DETACHED;
                            end else begin
                                att_reg[ri] <= 1'b0;
                            end
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end
                        OP_ADD_TAG: begin
                            if (tcount_reg < TCW'(TAG_SLOTS)) begin
                                tcount_reg <= tcount_reg + 1'b1;
                            end else begin
                                m_status_reg <= ST_TAG_FULL;
                            end
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end
                        OP_SPACE: begin
                            if (att_reg == '0) begin
                                m_space_reg  <= CNT_W'(bs_reg - 1'b1);
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= S_EMIT;
                            end else begin
                                mod_in_reg    <= MW'(wp_reg);
                                mod_start_reg <= 1'b1;
                                ret_reg       <= S_S0;
                                state_reg     <= S_MOD_WAIT;
                            end
                        end
                        OP_TAGS: begin
                            mask_reg  <= '0;
                            ti_reg    <= '0;
                            state_reg <= S_Q_RD;
                        end
                        default: begin
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end
                    endcase
                end
                S_MOD_WAIT: begin
                    if (mod_done) begin
                        state_reg <= ret_reg;
                    end
                end
                // commit
                S_C1: begin
                    mod_in_reg    <= MW'(mod_rem) + MW'(cnt_reg);
                    mod_start_reg <= 1'b1;
                    ret_reg       <= S_C2;
                    state_reg     <= S_MOD_WAIT;
                end
                S_C2: begin
                    wp_reg       <= mod_rem;
                    wtot_reg     <= wtot_reg + OFF_W'(cnt_reg);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_EMIT;
                end
                // consume
                S_N1: begin
                    mod_in_reg    <= MW'(mod_rem) + MW'(cnt_reg);
                    mod_start_reg <= 1'b1;
                    ret_reg       <= S_N2;
                    state_reg     <= S_MOD_WAIT;
                end
                S_N2: begin
                    rp_reg[ri]    <= mod_rem;
                    rtot_reg[ri]  <= rtot_reg[ri] + OFF_W'(cnt_reg);
                    tmp_reg       <= mod_rem;
                    mod_in_reg    <= MW'(wp_reg);
                    mod_start_reg <= 1'b1;
                    ret_reg       <= S_N3;
                    state_reg     <= S_MOD_WAIT;
                end
                S_N3: begin
                    m_backlog_reg <= CNT_W'(csub({1'b0, SW'(mod_rem)} + {1'b0, bs_reg}
                                                 - {1'b0, SW'(tmp_reg)}, bs_reg));
                    m_tvalid_reg  <= 1'b1;
                    state_reg     <= S_EMIT;
                end
                // attach with preload
                S_A1: begin
                    tmp_reg       <= mod_rem;
                    mod_in_reg    <= MW'(wp_reg);
                    mod_start_reg <= 1'b1;
                    ret_reg       <= S_A2;
                    state_reg     <= S_MOD_WAIT;
                end
                S_A2: begin
                    rp_reg[ri]   <= csub({1'b0, SW'(mod_rem)} + {1'b0, bs_reg}
                                         - {1'b0, SW'(tmp_reg)}, bs_reg);
                    rtot_reg[ri] <= '0;
                    att_reg[ri]  <= 1'b1;
                    tmp_reg      <= mod_rem;
                    state_reg    <= S_A3;
                end
                S_A3: begin
                    m_backlog_reg <= CNT_W'(csub({1'b0, SW'(tmp_reg)} + {1'b0, bs_reg}
                                                 - {1'b0, SW'(rp_reg[ri])}, bs_reg));
                    m_tvalid_reg  <= 1'b1;
                    state_reg     <= S_EMIT;
                end
                // space query: walk the reader slots
                S_S0: begin
                    tmp_reg   <= mod_rem;
                    idx_reg   <= '0;
                    any_reg   <= 1'b0;
                    most_reg  <= '0;
                    minr_reg  <= '0;
                    state_reg <= S_S1;
                end
                S_S1: begin
                    if (idx_reg == (RW + 1)'(READERS)) begin
                        state_reg <= S_SDONE;
                    end else if (att_reg[idx_reg[RW-1:0]]) begin
                        mod_in_reg    <= MW'(rp_reg[idx_reg[RW-1:0]]);
                        mod_start_reg <= 1'b1;
                        ret_reg       <= S_S2;
                        state_reg     <= S_MOD_WAIT;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_S2: begin
                    if (!any_reg || idx_back > most_reg) begin
                        most_reg <= idx_back;
                    end
                    if (!any_reg || idx_tot < minr_reg) begin
                        minr_reg <= idx_tot;
                    end
                    any_reg   <= 1'b1;
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_S1;
                end
                S_SDONE: begin
                    if (minr_reg != prior_reg) begin
                        // prune against the old minimum, then record the new one
                        ti_reg    <= '0;
                        keep_reg  <= '0;
                        state_reg <= S_P_RD;
                    end else begin
                        state_reg <= S_SOUT;
                    end
                end
                S_P_RD: begin
                    if (ti_reg == tcount_reg) begin
                        tcount_reg <= keep_reg;
                        prior_reg  <= minr_reg;
                        state_reg  <= S_SOUT;
                    end else begin
                        state_reg <= S_P_CHK;
                    end
                end
                S_P_CHK: begin
                    if (tag_rd_off >= prior_reg) begin
                        keep_reg <= keep_reg + 1'b1;
                    end
                    ti_reg    <= ti_reg + 1'b1;
                    state_reg <= S_P_RD;
                end
                S_SOUT: begin
                    m_space_reg  <= CNT_W'(bs_reg - SW'(most_reg) - 1'b1);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_EMIT;
                end
                // tag query: mark matches, then send them in table order
                S_Q_RD: begin
                    if (ti_reg == tcount_reg) begin
                        if (mask_reg == '0) begin
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_EMIT;
                        end else begin
                            ti_reg    <= '0;
                            nres_reg  <= '0;
                            state_reg <= S_E_SCAN;
                        end
                    end else begin
                        state_reg <= S_Q_CHK;
                    end
                end
                S_Q_CHK: begin
                    mask_reg[ti_reg[TW-1:0]] <= (tag_rd_off >= rs_reg) && (tag_rd_off < re_reg);
                    ti_reg    <= ti_reg + 1'b1;
                    state_reg <= S_Q_RD;
                end
                S_E_SCAN: begin
                    if (mask_reg[ti_reg[TW-1:0]]) begin
                        state_reg <= S_E_CHK;
                    end else begin
                        ti_reg <= ti_reg + 1'b1;
                    end
                end
                S_E_CHK: begin
                    m_found_reg  <= 1'b1;
                    m_off_reg    <= tag_rd_off;
                    m_pay_reg    <= tag_rd_pay;
                    m_tlast_reg  <= (mask_rest == '0) || (nres_reg == NW'(MAX_RESULTS - 1));
                    mask_reg     <= mask_rest;
                    ti_reg       <= ti_reg + 1'b1;
                    nres_reg     <= nres_reg + 1'b1;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_EMIT;
                end
                S_EMIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        state_reg    <= m_tlast_reg ? S_IDLE : S_E_SCAN;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {5'd0, m_pay_reg, m_off_reg, m_found_reg,
                       m_backlog_reg, m_space_reg, m_status_reg};

    // a result is never held while a new transaction can enter
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready)
        else $error("result pending while input ready");
    // an accepted transaction takes the block busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("block ready right after accept");
    // tag table never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        tcount_reg <= TCW'(TAG_SLOTS))
        else $error("tag count past table size");
    // size register stays in its clamped range
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bs_reg >= SW'(2)) && (bs_reg <= SW'(DEPTH)))
        else $error("buffer size out of range");
    // the remainder unit only finishes while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == S_MOD_WAIT))
        else $error("remainder done outside wait");

endmodule
`default_nettype wire

>>> verif/testbench.sv
module testbench;
    import mrrp_pkg::*;

    // one result transaction as seen on the master side
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] space_free;
        logic [11:0] backlog;
        logic        tag_found;
        logic [63:0] found_offset;
        logic [31:0] found_payload;
        logic        last;
    } ring_reply_t;

    class ring_scoreboard;
        bit [12:0]   size_q;
        bit [11:0]   wr_pos;
        bit [63:0]   wr_total;
        bit [11:0]   rd_pos[8];
        bit [63:0]   rd_total[8];
        bit          is_attached[8];
        bit [63:0]   last_min_read;
        bit [63:0]   tag_off[16];
        bit [31:0]   tag_pay[16];
        int          tag_num;
        ring_reply_t pending[$];
        int          mismatches;

        function new();
            size_q        = 13'd4096;
            wr_pos        = '0;
            wr_total      = '0;
            last_min_read = '0;
            tag_num       = 0;
            mismatches    = 0;
            foreach (is_attached[i]) begin
                is_attached[i] = 1'b0;
                rd_pos[i]      = '0;
                rd_total[i]    = '0;
            end
        endfunction

        function void set_size(bit [12:0] v);
            if (v < 2) v = 2;
            if (v > 4096) v = 4096;
            size_q = v;
        endfunction

        function bit [11:0] ring_add(bit [11:0] a, bit [11:0] n);
            int unsigned s;
            s = size_q;
            return 12'(((a % s) + n) % s);
        endfunction

        function bit [11:0] ring_diff(bit [11:0] a, bit [11:0] b);
            int unsigned s;
            s = size_q;
            return 12'(((a % s) + s - (b % s)) % s);
        endfunction

        function void push(bit [1:0] st, bit [11:0] sp, bit [11:0] bl, bit tf,
                           bit [63:0] off, bit [31:0] pay, bit lst);
            ring_reply_t e;
            e.status = st; e.space_free = sp; e.backlog = bl; e.tag_found = tf;
            e.found_offset = off; e.found_payload = pay; e.last = lst;
            pending = {pending, e};
        endfunction

        // predict the replies of one accepted request
        function void note_request(op_t op, logic [239:0] d);
            bit [2:0]  r;
            bit [11:0] cnt;
            bit [63:0] noff, rs, re, min_read;
            bit [31:0] npay;
            bit        any;
            bit [11:0] most, b;
            int        n, keep;
            r = d[2:0]; cnt = d[14:3]; noff = d[78:15]; npay = d[110:79];
            rs = d[174:111]; re = d[238:175];
            case (op)
                OP_COMMIT: begin
                    wr_pos   = ring_add(wr_pos, cnt);
                    wr_total = wr_total + cnt;
                    push(ST_OK, 0, 0, 0, 0, 0, 1);
                end
                OP_CONSUME: begin
                    if (!is_attached[r]) push(ST_DETACHED, 0, 0, 0, 0, 0, 1);
                    else begin
                        rd_pos[r]   = ring_add(rd_pos[r], cnt);
                        rd_total[r] = rd_total[r] + cnt;
                        push(ST_OK, 0, ring_diff(wr_pos, rd_pos[r]), 0, 0, 0, 1);
                    end
                end
                OP_ATTACH: begin
                    rd_pos[r]      = ring_diff(wr_pos, cnt);
                    rd_total[r]    = '0;
                    is_attached[r] = 1'b1;
                    push(ST_OK, 0, ring_diff(wr_pos, rd_pos[r]), 0, 0, 0, 1);
                end
                OP_DETACH: begin
                    if (!is_attached[r]) push(ST_DETACHED, 0, 0, 0, 0, 0, 1);
                    else begin
                        is_attached[r] = 1'b0;
                        push(ST_OK, 0, 0, 0, 0, 0, 1);
                    end
                end
                OP_ADD_TAG: begin
                    if (tag_num >= 16) push(ST_TAG_FULL, 0, 0, 0, 0, 0, 1);
                    else begin
                        tag_off[tag_num] = noff;
                        tag_pay[tag_num] = npay;
                        tag_num++;
                        push(ST_OK, 0, 0, 0, 0, 0, 1);
                    end
                end
                OP_SPACE: begin
                    any = 0; most = 0; min_read = 0;
                    for (int i = 0; i < 8; i++) begin
                        if (is_attached[i]) begin
                            b = ring_diff(wr_pos, rd_pos[i]);
                            if (!any || b > most) most = b;
                            if (!any || rd_total[i] < min_read) min_read = rd_total[i];
                            any = 1;
                        end
                    end
                    if (!any) push(ST_OK, 12'(size_q - 1), 0, 0, 0, 0, 1);
                    else begin
                        // prune against the previous minimum, then remember the new one
                        if (min_read != last_min_read) begin
                            keep = 0;
                            for (int i = 0; i < tag_num; i++) begin
                                if (tag_off[i] >= last_min_read) begin
                                    tag_off[keep] = tag_off[i];
                                    tag_pay[keep] = tag_pay[i];
                                    keep++;
                                end
                            end
                            tag_num       = keep;
                            last_min_read = min_read;
                        end
                        push(ST_OK, 12'(size_q - most - 1), 0, 0, 0, 0, 1);
                    end
                end
                OP_TAGS: begin
                    n = 0;
                    for (int i = 0; i < tag_num && n < 16; i++) begin
                        if (tag_off[i] >= rs && tag_off[i] < re) begin
                            push(ST_OK, 0, 0, 1, tag_off[i], tag_pay[i], 0);
                            n++;
                        end
                    end
                    if (n == 0) push(ST_OK, 0, 0, 0, 0, 0, 1);
                    else pending[pending.size()-1].last = 1'b1;
                end
                default: push(ST_OK, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        function void check_reply(logic [127:0] d, logic lst);
            ring_reply_t e, a;
            a.status = d[1:0]; a.space_free = d[13:2]; a.backlog = d[25:14];
            a.tag_found = d[26]; a.found_offset = d[90:27]; a.found_payload = d[122:91];
            a.last = lst;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected reply %h last %b", d, lst);
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("reply mismatch: exp st %0d sp %0d bl %0d tf %b off %h",
                        e.status, e.space_free, e.backlog, e.tag_found, e.found_offset,
                        " pay %h last %b,", e.found_payload, e.last,
                        " got st %0d sp %0d bl %0d tf %b off %h",
                        a.status, a.space_free, a.backlog, a.tag_found, a.found_offset,
                        " pay %h last %b", a.found_payload, a.last);
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [12:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // reader, count, new_tag_offset, new_tag_payload, range_start, range_end
    logic [239:0] s_tdata = '0;
    // operation
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, space_free, backlog, tag_found, found_offset, found_payload
    logic [127:0] m_tdata;
    logic         m_tlast;

    ring_scoreboard sb = new();
    int send_idle = 0;    // percent of cycles the sender holds off
    int recv_idle = 0;    // percent of cycles the receiver stalls
    int quiet_cycles = 0;

    always #2 aclk = ~aclk;

    multi_reader_ring_pointer_tags i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // receiver backpressure, changed on the falling edge
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    // both monitors plus the no-progress watchdog
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(op_t'(s_tuser), s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tlast);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one request transaction; valid stays high into the next call when no gap follows
    task automatic send_req(op_t op, bit [2:0] r, bit [11:0] cnt, bit [63:0] noff,
                            bit [31:0] npay, bit [63:0] rs, bit [63:0] re);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {1'b0, re, rs, npay, noff, cnt, r};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_and_configure(bit [12:0] v);
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (60) @(posedge aclk);   // let the remainder unit settle
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_size(v);
    endtask

    task automatic random_req();
        int        pick;
        bit [2:0]  r;
        bit [11:0] cnt;
        bit [63:0] noff, rs, re, base;
        pick = $urandom_range(99);
        r    = $urandom_range(7);
        cnt  = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(sb.size_q / 2));
        base = sb.wr_total;
        // tag offsets mostly near the stream position so pruning and queries hit
        noff = ($urandom_range(7) == 0) ? {$urandom, $urandom} : base + $urandom_range(600);
        rs   = ($urandom_range(7) == 0) ? {$urandom, $urandom} : base - $urandom_range(400);
        re   = ($urandom_range(5) == 0) ? 64'hffff_ffff_ffff_ffff : rs + $urandom_range(900);
        if (pick < 15)      send_req(OP_COMMIT, r, cnt, noff, $urandom, rs, re);
        else if (pick < 35) send_req(OP_CONSUME, r, cnt, noff, $urandom, rs, re);
        else if (pick < 45) send_req(OP_ATTACH, r, 12'(cnt % sb.size_q), noff, $urandom, rs, re);
        else if (pick < 50) send_req(OP_DETACH, r, cnt, noff, $urandom, rs, re);
        else if (pick < 62) send_req(OP_ADD_TAG, r, cnt, noff, $urandom, rs, re);
        else if (pick < 80) send_req(OP_SPACE, r, cnt, noff, $urandom, rs, re);
        else if (pick < 96) send_req(OP_TAGS, r, cnt, noff, $urandom, rs, re);
        else                send_req(OP_NONE, r, cnt, noff, $urandom, rs, re);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty ring, extremes, unattached slots, full tag table
        send_req(OP_SPACE, 0, 0, 0, 0, 0, 0);
        send_req(OP_COMMIT, 0, 12'hfff, 0, 0, 0, 0);
        send_req(OP_ATTACH, 0, 0, 0, 0, 0, 0);
        send_req(OP_ATTACH, 7, 12'hfff, 0, 0, 0, 0);
        send_req(OP_CONSUME, 3, 5, 0, 0, 0, 0);
        send_req(OP_DETACH, 5, 0, 0, 0, 0, 0);
        send_req(OP_CONSUME, 0, 100, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_req(OP_ADD_TAG, 0, 0, (i == 0) ? 64'd0 : (i == 16) ? '1 : 64'(i * 50),
                     (i == 1) ? '1 : $urandom, 0, 0);
        send_req(OP_TAGS, 0, 0, 0, 0, 0, 64'hffff_ffff_ffff_ffff);
        send_req(OP_TAGS, 4, 0, 0, 0, 64'd5000, 64'd5000);
        send_req(OP_SPACE, 0, 0, 0, 0, 0, 0);
        send_req(OP_NONE, 7, 12'hfff, '1, '1, '1, '1);
        send_req(OP_DETACH, 7, 0, 0, 0, 0, 0);
        send_req(OP_ATTACH, 0, 3, 0, 0, 0, 0);

        // random phases over several sizes and idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: drain_and_configure(13'd0);
                1: drain_and_configure(13'h1fff);
                2: drain_and_configure(13'($urandom_range(2, 64)));
                default: drain_and_configure(13'd4096);
            endcase
            send_idle = (ph == 0) ? 25 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 25 : 0;
            for (int k = 0; k < 43; k++) random_req();
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (300) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> sim.f
design/mrrp_pkg.sv
design/mrrp_mod.sv
design/multi_reader_ring_pointer_tags.sv
verif/testbench.sv
